// ===== rtl/core/sst_pkg.sv =====
// Package for the speech segment tracker.
// Holds the shared widths, register indexes, event codes, reset values and the structs
// that pass between the modules. Depends on nothing.
package sst_pkg;

   localparam int PROB_BITS  = 16;
   localparam int TIME_BITS  = 48;
   localparam int TS_BITS    = 48;
   localparam int REL_BITS   = 32;
   localparam int WIN_BITS   = 16;
   localparam int LEN_BITS   = 24;
   localparam int IDLE_BITS  = 32;
   localparam int CSR_DBITS  = 32;
   localparam int CSR_ABITS  = 3;

   typedef enum logic [CSR_ABITS-1:0] {
      REG_THRESHOLD      = 3'd0,
      REG_RELEASE_MARGIN = 3'd1,
      REG_WINDOW_SAMPLES = 3'd2,
      REG_MIN_SILENCE    = 3'd3,
      REG_MIN_SPEECH     = 3'd4,
      REG_IDLE_RESET     = 3'd5
   } csr_index_type;

   typedef enum logic [2:0] {
      EV_NONE    = 3'd0,
      EV_START   = 3'd1,
      EV_END     = 3'd2,
      EV_MANUAL  = 3'd3,
      EV_SILENCE = 3'd4
   } event_type;

   localparam logic [PROB_BITS-1:0] THRESHOLD_RST      = PROB_BITS'(32768);
   localparam logic [PROB_BITS-1:0] RELEASE_MARGIN_RST = PROB_BITS'(9830);
   localparam logic [WIN_BITS-1:0]  WINDOW_SAMPLES_RST = WIN_BITS'(512);
   localparam logic [LEN_BITS-1:0]  MIN_SILENCE_RST    = LEN_BITS'(1600);
   localparam logic [LEN_BITS-1:0]  MIN_SPEECH_RST     = LEN_BITS'(4000);
   localparam logic [IDLE_BITS-1:0] IDLE_RESET_RST     = '0;

   typedef struct packed {
      logic [PROB_BITS-1:0] threshold;
      logic [PROB_BITS-1:0] release_margin;
      logic [WIN_BITS-1:0]  window_samples;
      logic [LEN_BITS-1:0]  silence_len;
      logic [LEN_BITS-1:0]  speech_len;
      logic [IDLE_BITS-1:0] idle_reset_samples;
   } cfg_type;

   typedef struct packed {
      logic                 active;
      logic [REL_BITS-1:0]  pending_end;
      logic [REL_BITS-1:0]  segment_start;
      logic [REL_BITS-1:0]  relative_count;
      logic [TIME_BITS-1:0] global_count;
      logic [TIME_BITS-1:0] last_speech_mark;
   } seg_state_type;

   typedef struct packed {
      event_type            event_res;
      logic [TS_BITS-1:0]   timestamp;
      logic                 long_enough;
      logic                 in_speech;
   } result_type;

endpackage

// ===== rtl/core/speech_segment_tracker.sv =====
// Top level of the speech segment tracker: input register, segmentation state,
// result register and configuration registers. Depends on sst_pkg, sst_csr, sst_step.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_mode, req_speech_prob
//   rsp      out        rsp_valid/rsp_stall  rsp_event_res, rsp_timestamp,
//                                            rsp_long_enough, rsp_in_speech
//   csr      in         csr_we               csr_index, csr_wdata
//
// One transaction per cycle sustained while rsp_stall is low; each request passes
// through the input register, then the result register.
// The segmentation state advances in the same cycle as the result register loads.
// Synchronous reset clears both valid flags, the segmentation state and the
// configuration registers to their defaults.
// rsp_stall, while rsp_valid is set, holds the result register and, once the input
// register is full, raises req_stall in the same cycle.
module speech_segment_tracker
   import sst_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_mode,
   input  logic [PROB_BITS-1:0] req_speech_prob,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [2:0]           rsp_event_res,
   output logic [TS_BITS-1:0]   rsp_timestamp,
   output logic                 rsp_long_enough,
   output logic                 rsp_in_speech,
   input  logic                 csr_we,
   input  logic [CSR_ABITS-1:0] csr_index,
   input  logic [CSR_DBITS-1:0] csr_wdata
);

   cfg_type              cfg;
   logic                 in_valid_ff;
   logic                 in_mode_ff;
   logic [PROB_BITS-1:0] in_prob_ff;
   logic                 rsp_valid_ff;
   result_type           rsp_ff;
   seg_state_type        st_ff;
   seg_state_type        st_in;
   result_type           res_in;
   logic                 out_free;
   logic                 step_fire;
   logic                 req_take;

   sst_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   sst_step u_step (
      .cfg     (cfg),
      .st      (st_ff),
      .mode    (in_mode_ff),
      .prob    (in_prob_ff),
      .st_next (st_in),
      .res     (res_in)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign step_fire = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (step_fire) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_mode_ff <= req_mode;
         in_prob_ff <= req_speech_prob;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step_fire) begin
         rsp_ff <= res_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= '0;
      end else if (step_fire) begin
         st_ff <= st_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_event_res   = rsp_ff.event_res;
   assign rsp_timestamp   = rsp_ff.timestamp;
   assign rsp_long_enough = rsp_ff.long_enough;
   assign rsp_in_speech   = rsp_ff.in_speech;

   a_start_opens : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_event_res == EV_START)) |-> rsp_in_speech)
      else $error("start transaction without open segment");

   a_close_events : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && ((rsp_event_res == EV_END) || (rsp_event_res == EV_MANUAL) ||
                     (rsp_event_res == EV_SILENCE))) |-> !rsp_in_speech)
      else $error("closing transaction leaves segment open");

   a_long_only_end : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_long_enough) |-> (rsp_event_res == EV_END))
      else $error("long_enough set outside end transaction");

   a_state_matches : assert property (@(posedge clock) disable iff (reset)
      step_fire |=> (rsp_in_speech == st_ff.active))
      else $error("reported speech flag differs from segment state");

endmodule

// ===== rtl/core/sst_csr.sv =====
// Configuration registers of the speech segment tracker.
// Depends on sst_pkg for the register indexes, reset values and cfg_type.
module sst_csr
   import sst_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_ABITS-1:0] csr_index,
   input  logic [CSR_DBITS-1:0] csr_wdata,
   output cfg_type              cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_THRESHOLD:      cfg_in.threshold          = csr_wdata[PROB_BITS-1:0];
            REG_RELEASE_MARGIN: cfg_in.release_margin     = csr_wdata[PROB_BITS-1:0];
            REG_WINDOW_SAMPLES: cfg_in.window_samples     = csr_wdata[WIN_BITS-1:0];
            REG_MIN_SILENCE:    cfg_in.silence_len        = csr_wdata[LEN_BITS-1:0];
            REG_MIN_SPEECH:     cfg_in.speech_len         = csr_wdata[LEN_BITS-1:0];
            REG_IDLE_RESET:     cfg_in.idle_reset_samples = csr_wdata[IDLE_BITS-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold          <= THRESHOLD_RST;
         cfg_ff.release_margin     <= RELEASE_MARGIN_RST;
         cfg_ff.window_samples     <= WINDOW_SAMPLES_RST;
         cfg_ff.silence_len        <= MIN_SILENCE_RST;
         cfg_ff.speech_len         <= MIN_SPEECH_RST;
         cfg_ff.idle_reset_samples <= IDLE_RESET_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/core/sst_step.sv =====
// Next-state and result logic for one transaction of the speech segment tracker.
// Purely combinational; depends on sst_pkg for the state, config and result types.
module sst_step
   import sst_pkg::*;
(
   input  cfg_type              cfg,
   input  seg_state_type        st,
   input  logic                 mode,
   input  logic [PROB_BITS-1:0] prob,
   output seg_state_type        st_next,
   output result_type           res
);

   logic [TIME_BITS-1:0] glob_n;
   logic [REL_BITS-1:0]  rel_n;
   logic                 is_speech;
   logic                 below_release;
   logic [REL_BITS-1:0]  pend_take;
   logic                 silence_met;
   logic                 long_seg;

   assign glob_n        = st.global_count + TIME_BITS'(cfg.window_samples);
   assign rel_n         = st.relative_count + REL_BITS'(cfg.window_samples);
   assign is_speech     = prob >= cfg.threshold;
   assign below_release = (cfg.threshold >= cfg.release_margin) &&
                          (({1'b0, prob} + {1'b0, cfg.release_margin}) <
                           {1'b0, cfg.threshold});
   assign pend_take     = (st.pending_end == '0) ? rel_n : st.pending_end;
   assign silence_met   = (rel_n - pend_take) >= REL_BITS'(cfg.silence_len);
   assign long_seg      = (pend_take - st.segment_start) >
                          REL_BITS'(cfg.speech_len);

   always_comb begin
      logic [TIME_BITS-1:0] ts;
      st_next         = st;
      res.event_res   = EV_NONE;
      res.long_enough = 1'b0;
      ts              = glob_n;
      if (mode) begin
         st_next.active           = 1'b0;
         st_next.pending_end      = '0;
         st_next.segment_start    = '0;
         st_next.relative_count   = '0;
         st_next.last_speech_mark = st.global_count;
         res.event_res            = EV_MANUAL;
         ts                       = st.global_count;
      end else begin
         st_next.relative_count = rel_n;
         st_next.global_count   = glob_n;
         if (is_speech) begin
            if (!st.active) begin
               st_next.active        = 1'b1;
               st_next.segment_start = st.relative_count;
               res.event_res         = EV_START;
               ts                    = st.global_count;
            end
            st_next.pending_end = '0;
         end else if (st.active && below_release) begin
            st_next.pending_end = pend_take;
            if (silence_met) begin
               res.long_enough          = long_seg;
               res.event_res            = EV_END;
               st_next.active           = 1'b0;
               st_next.pending_end      = '0;
               st_next.segment_start    = '0;
               st_next.relative_count   = '0;
               st_next.last_speech_mark = glob_n;
            end
         end
         if (st_next.active) begin
            st_next.last_speech_mark = glob_n;
         end
         if ((res.event_res == EV_NONE) && !st_next.active &&
             (cfg.idle_reset_samples != '0) &&
             ((glob_n - st_next.last_speech_mark) >=
              TIME_BITS'(cfg.idle_reset_samples))) begin
            st_next.active           = 1'b0;
            st_next.pending_end      = '0;
            st_next.segment_start    = '0;
            st_next.relative_count   = '0;
            st_next.last_speech_mark = glob_n;
            res.event_res            = EV_SILENCE;
         end
      end
      res.timestamp = TS_BITS'(ts);
      res.in_speech = st_next.active;
   end

endmodule
